/* rtl/xtea_pkg.sv */
// Shared types, constants and the round function for the XTEA block cipher.
`timescale 1ns / 1ps
`default_nettype none

package xtea_pkg;

	localparam int unsigned WORD_W          = 32;
	localparam int unsigned KEY_WORDS       = 4;
	localparam int unsigned CFG_INDEX_W     = 8;
	localparam int unsigned ROUND_COUNT_DFLT = 32;
	localparam int unsigned QUEUE_DEPTH_DFLT = 2;

	localparam logic [WORD_W-1:0] XTEA_DELTA = 32'h9E37_79B9;

	localparam logic OP_ENCRYPT = 1'b0;
	localparam logic OP_DECRYPT = 1'b1;

	// Register indexes of the configuration port.
	localparam logic [CFG_INDEX_W-1:0] REG_KEY_ZERO  = 8'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_KEY_ONE   = 8'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_KEY_TWO   = 8'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_KEY_THREE = 8'd3;

	typedef logic [KEY_WORDS-1:0][WORD_W-1:0] xtea_key_t;

	// One block in flight, with its direction and running round sum.
	typedef struct packed {
		logic              op;
		logic [WORD_W-1:0] hi;
		logic [WORD_W-1:0] lo;
		logic [WORD_W-1:0] sum;
	} xtea_item_t;

	function automatic logic [WORD_W-1:0] mix_word(input logic [WORD_W-1:0] x);
		return ((x << 4) ^ (x >> 5)) + x;
	endfunction

endpackage

`default_nettype wire

/* rtl/xtea_front.sv */
// Front end: takes an item, registers it and sets its starting round sum.
`timescale 1ns / 1ps
`default_nettype none

module xtea_front #(
	parameter int unsigned ROUND_COUNT = xtea_pkg::ROUND_COUNT_DFLT
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	input  wire logic                        operation,
	input  wire logic [xtea_pkg::WORD_W-1:0] block_high,
	input  wire logic [xtea_pkg::WORD_W-1:0] block_low,
	output logic                             busy,
	input  wire logic                        queue_full,
	output logic                             push,
	output xtea_pkg::xtea_item_t             push_item
);
	import xtea_pkg::*;

	// Decryption walks the sum down from DELTA times the round count.
	localparam logic [WORD_W-1:0] SUM_DECRYPT =
		WORD_W'(64'(XTEA_DELTA) * 64'(ROUND_COUNT));

	logic       valid_q;
	xtea_item_t item_q;
	logic       take;

	assign push = valid_q && !queue_full;
	assign busy = valid_q && !push;
	assign take = start && !busy;
	assign push_item = item_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (take) begin
			valid_q <= 1'b1;
		end else if (push) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_q.op  <= operation;
			item_q.hi  <= block_high;
			item_q.lo  <= block_low;
			item_q.sum <= (operation == OP_DECRYPT) ? SUM_DECRYPT : '0;
		end
	end

endmodule

`default_nettype wire

/* rtl/xtea_queue.sv */
// Short item queue between the front end and the round pipeline.
`timescale 1ns / 1ps
`default_nettype none

module xtea_queue #(
	parameter int unsigned DEPTH = xtea_pkg::QUEUE_DEPTH_DFLT
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 push,
	input  wire xtea_pkg::xtea_item_t push_item,
	output logic                      full,
	input  wire logic                 pop,
	output logic                      not_empty,
	output xtea_pkg::xtea_item_t      pop_item
);
	import xtea_pkg::*;

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	xtea_item_t       mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full      = (count_q == FULL_CNT);
	assign not_empty = (count_q != '0);
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;
	assign pop_item  = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

`default_nettype wire

/* rtl/xtea_back.sv */
// Round pipeline: one register stage per half round, one item per cycle.
`timescale 1ns / 1ps
`default_nettype none

module xtea_back #(
	parameter int unsigned ROUND_COUNT = xtea_pkg::ROUND_COUNT_DFLT
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire xtea_pkg::xtea_key_t         key,
	input  wire logic                        in_valid,
	input  wire xtea_pkg::xtea_item_t        in_item,
	output logic                             out_valid,
	output logic [xtea_pkg::WORD_W-1:0]      out_high,
	output logic [xtea_pkg::WORD_W-1:0]      out_low
);
	import xtea_pkg::*;

	localparam int unsigned STAGES = 2 * ROUND_COUNT;

	logic       valid_s [STAGES+1];
	xtea_item_t item_s  [STAGES+1];

	assign valid_s[0] = in_valid;
	assign item_s[0]  = in_item;

	for (genvar j = 0; j < STAGES; j++) begin : g_stage
		// Even stages update the word that leads the round and step the sum;
		// odd stages update the other word. Decryption swaps the roles.
		localparam bit EVEN = (j % 2) == 0;

		logic              upd_hi;
		logic [WORD_W-1:0] src;
		logic [WORD_W-1:0] dst;
		logic [1:0]        kidx;
		logic [WORD_W-1:0] term;
		logic [WORD_W-1:0] dst_nxt;
		logic [WORD_W-1:0] sum_nxt;
		xtea_item_t        cur;

		assign cur    = item_s[j];
		assign upd_hi = EVEN ? (cur.op == OP_ENCRYPT) : (cur.op == OP_DECRYPT);
		assign src    = upd_hi ? cur.lo : cur.hi;
		assign dst    = upd_hi ? cur.hi : cur.lo;
		assign kidx   = upd_hi ? cur.sum[1:0] : cur.sum[12:11];
		assign term   = mix_word(src) ^ (cur.sum + key[kidx]);

		always_comb begin
			if (cur.op == OP_DECRYPT) begin
				dst_nxt = dst - term;
				sum_nxt = EVEN ? cur.sum - XTEA_DELTA : cur.sum;
			end else begin
				dst_nxt = dst + term;
				sum_nxt = EVEN ? cur.sum + XTEA_DELTA : cur.sum;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[j+1] <= 1'b0;
			end else begin
				valid_s[j+1] <= valid_s[j];
			end
		end

		always_ff @(posedge clk) begin
			item_s[j+1].op  <= cur.op;
			item_s[j+1].sum <= sum_nxt;
			item_s[j+1].hi  <= upd_hi ? dst_nxt : cur.hi;
			item_s[j+1].lo  <= upd_hi ? cur.lo : dst_nxt;
		end
	end

	assign out_valid = valid_s[STAGES];
	assign out_high  = item_s[STAGES].hi;
	assign out_low   = item_s[STAGES].lo;

endmodule

`default_nettype wire

/* rtl/xtea_block_cipher.sv */
// Top level of the XTEA block cipher: key registers, front end, queue, rounds.
// A start passes through the front-end register, the queue and the half-round stages to result_valid.
// Throughput: one item per cycle while busy is low, set by the fully pipelined half-round stages.
// The result is shown for one cycle on result_valid; the receiver cannot stall,
// so with a QUEUE_DEPTH of two or more the queue never backs up and busy stays low.
// Reset clears all valid flags and the queue, and sets the four key words to zero.
`timescale 1ns / 1ps
`default_nettype none

module xtea_block_cipher #(
	parameter int unsigned ROUND_COUNT = xtea_pkg::ROUND_COUNT_DFLT,
	parameter int unsigned QUEUE_DEPTH = xtea_pkg::QUEUE_DEPTH_DFLT
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_we,
	input  wire logic [xtea_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [xtea_pkg::WORD_W-1:0]      cfg_data,
	input  wire logic                             start,
	output logic                                  busy,
	input  wire logic                             operation,
	input  wire logic [xtea_pkg::WORD_W-1:0]      block_high,
	input  wire logic [xtea_pkg::WORD_W-1:0]      block_low,
	output logic                                  result_valid,
	output logic [xtea_pkg::WORD_W-1:0]           result_high,
	output logic [xtea_pkg::WORD_W-1:0]           result_low
);
	import xtea_pkg::*;

	xtea_key_t  key_q;
	logic       queue_full;
	logic       push;
	xtea_item_t push_item;
	logic       not_empty;
	xtea_item_t pop_item;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_KEY_ZERO:  key_q[0] <= cfg_data;
				REG_KEY_ONE:   key_q[1] <= cfg_data;
				REG_KEY_TWO:   key_q[2] <= cfg_data;
				REG_KEY_THREE: key_q[3] <= cfg_data;
				default: ;
			endcase
		end
	end

	xtea_front #(
		.ROUND_COUNT(ROUND_COUNT)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.operation  (operation),
		.block_high (block_high),
		.block_low  (block_low),
		.busy       (busy),
		.queue_full (queue_full),
		.push       (push),
		.push_item  (push_item)
	);

	xtea_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (queue_full),
		.pop       (not_empty),
		.not_empty (not_empty),
		.pop_item  (pop_item)
	);

	// The round pipeline never stalls, so it drains the queue every cycle.
	xtea_back #(
		.ROUND_COUNT(ROUND_COUNT)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.key       (key_q),
		.in_valid  (not_empty),
		.in_item   (pop_item),
		.out_valid (result_valid),
		.out_high  (result_high),
		.out_low   (result_low)
	);

endmodule

`default_nettype wire
